FILE: sv/grid_trilinear_interpolator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid trilinear interpolator
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef GRID_TRILINEAR_INTERPOLATOR_MACROS_SVH
`define GRID_TRILINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define GTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gti_pkg.sv
// ---------------------------------------------------------------------------
// gti_pkg
// Shared constants and types of the grid trilinear interpolator.
// ---------------------------------------------------------------------------
package gti_pkg;

  localparam int DATA_W      = 32;
  localparam int SIZE1_W     = 7;
  localparam int SIZE2_W     = 7;
  localparam int SIZE3_W     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 104;
  localparam int FRAC_OUT_W  = 17;
  localparam int BASE12_W    = 6;
  localparam int BASE3_W     = 5;

  // item kinds on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X1    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X2    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X2     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X3     = 3'd7;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

FILE: sv/grid_trilinear_interpolator.sv
// A cell write gives no result beat; a query gives one result beat.
// The query result is held in the output register, and the next item is
// taken only after the result has been loaded into that register.
// A query passes through the periodic-axis remainder unit, eight corner reads
// from the single-port grid memory and seven blends on one shared multiplier.
// Reset (rst, synchronous) restores register defaults; the grid is not cleared.
// ---------------------------------------------------------------------------
// grid_trilinear_interpolator
// Cell-centered 3D scalar grid with trilinear query, Q16.16 arithmetic.
// ---------------------------------------------------------------------------
module grid_trilinear_interpolator import gti_pkg::*; #(
  parameter int LOG_CELLS_X1 = 6,
  parameter int LOG_CELLS_X2 = 6,
  parameter int LOG_CELLS_X3 = 5,
  parameter int FRAC_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // cell_i[5:0] cell_j[11:6] cell_k[16:12] cell_value[48:17]
  // pos_x1[80:49] pos_x2[112:81] pos_x3[144:113], zero pad above
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  logic                   s_axis_tuser,
  // value[31:0] base_i[37:32] base_j[43:38] base_k[48:44]
  // frac_x1[65:49] frac_x2[82:66] frac_x3[99:83], zero pad above
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  localparam int FB      = FRAC_BITS;
  localparam int LOG_A   = (LOG_CELLS_X1 > LOG_CELLS_X2) ? LOG_CELLS_X1 : LOG_CELLS_X2;
  localparam int LOG_MAX = (LOG_A > LOG_CELLS_X3) ? LOG_A : LOG_CELLS_X3;
  localparam int N_W     = LOG_MAX + 1;
  localparam int CW      = (N_W > SIZE1_W) ? N_W : SIZE1_W;
  localparam int ADDR_W  = LOG_CELLS_X1 + LOG_CELLS_X2 + LOG_CELLS_X3;
  localparam int T_W     = 65 - FB;
  localparam int IQ_W    = 65 - 2 * FB;
  localparam int R_W     = N_W + FB;
  localparam int LOC_W   = N_W + FB + 1;

  localparam logic [T_W-1:0]  HALF_T = {{(T_W-1){1'b0}}, 1'b1} << (FB - 1);
  localparam logic [FB:0]     ONE_F  = {1'b1, {FB{1'b0}}};
  localparam logic [64:0]     MASK_Q = {{(65-FB){1'b0}}, {FB{1'b1}}};
  localparam logic [CW-1:0]   CAP1   = CW'(2**LOG_CELLS_X1);
  localparam logic [CW-1:0]   CAP2   = CW'(2**LOG_CELLS_X2);
  localparam logic [CW-1:0]   CAP3   = CW'(2**LOG_CELLS_X3);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LOC   = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_BLEND = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // size in use, clamped to [2, memory extent]
  function automatic logic [CW-1:0] eff_size(input logic [CW-1:0] n,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] r;
    r = n;
    if (n < CW'(2)) r = CW'(2);
    else if (n > cap) r = cap;
    return r;
  endfunction

  // map a cell-unit coordinate to {lower index, upper weight}
  function automatic logic [LOC_W-1:0] locate(input logic neg,
                                              input logic [T_W-1:0] t,
                                              input logic [N_W-1:0] n);
    logic [T_W-1:0]    s;
    logic [T_W-FB-1:0] q;
    logic [N_W-1:0]    idx;
    logic [FB:0]       fr;
    s = t - HALF_T;
    q = s[T_W-1:FB];
    if (neg || (t < HALF_T)) begin
      idx = '0;
      fr  = '0;
    end else if (q > (T_W-FB)'(n - N_W'(2))) begin
      idx = n - N_W'(2);
      fr  = ONE_F;
    end else begin
      idx = q[N_W-1:0];
      fr  = {1'b0, s[FB-1:0]};
    end
    return {idx, fr};
  endfunction

  // configuration
  logic [DATA_W-1:0]  start_x1, start_x2;
  logic [DATA_W-1:0]  inv_step_x1, inv_step_x2, inv_step_x3;
  logic [SIZE1_W-1:0] size_x1;
  logic [SIZE2_W-1:0] size_x2;
  logic [SIZE3_W-1:0] size_x3;

  // sequencer and query state
  logic [2:0]        state;
  logic [DATA_W-1:0] pos1, pos2, pos3;
  logic [64:0]       prod1, prod2;
  logic [63:0]       prod3;
  logic              neg1, neg2, neg3;
  logic [N_W-1:0]    idx1, idx2, idx3;
  logic [FB:0]       f1, f2, f3;
  logic [FB-1:0]     low3;
  logic [2:0]        cnt;
  logic              rd_pend;
  logic [2:0]        rd_tag;
  logic [2:0]        step;
  logic              issued;
  logic [DATA_W-1:0] c0, c1, c2, c3, c4, c5, c6, c7;
  logic [DATA_W-1:0] w0, w1, w2, w3, w4, w5;
  logic signed [DATA_W:0] w6;

  // output register
  logic              m_valid;
  logic [DATA_W-1:0] o_value;
  logic [BASE12_W-1:0] o_base_i, o_base_j;
  logic [BASE3_W-1:0]  o_base_k;
  logic [FRAC_OUT_W-1:0] o_frac1, o_frac2, o_frac3;

  // combinational paths
  logic              in_accept;
  logic [N_W-1:0]    n1, n2, n3;
  logic [32:0]       d1, d2, mag1, mag2;
  logic [DATA_W-1:0] mag3;
  logic [64:0]       prod1_c, prod2_c;
  logic [63:0]       prod3_c;
  logic [LOC_W-1:0]  loc1, loc2, loc3;
  logic [64:0]       q3;
  logic [R_W-1:0]    r0, r3, period3;
  logic [N_W-1:0]    ci, cj, ck;
  logic [ADDR_W-1:0] rd_addr, wr_addr, mem_addr;
  logic              mem_we;
  logic [DATA_W-1:0] mem_rdata;
  logic [N_W-1:0]    mod_rem;
  mod_status_t       mod_status;
  logic              mod_start;
  logic              lerp_start;
  logic [DATA_W-1:0] lerp_a, lerp_b;
  logic [FB:0]       lerp_f;
  logic signed [DATA_W:0] lerp_res;
  logic              lerp_done;
  logic [DATA_W-1:0] v_sat;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign n1 = N_W'(eff_size(CW'(size_x1), CAP1));
  assign n2 = N_W'(eff_size(CW'(size_x2), CAP2));
  assign n3 = N_W'(eff_size(CW'(size_x3), CAP3));

  // offsets from origin and their magnitudes, axis three starts at zero
  assign d1      = {pos1[DATA_W-1], pos1} - {start_x1[DATA_W-1], start_x1};
  assign d2      = {pos2[DATA_W-1], pos2} - {start_x2[DATA_W-1], start_x2};
  assign mag1    = d1[32] ? (~d1 + 33'd1) : d1;
  assign mag2    = d2[32] ? (~d2 + 33'd1) : d2;
  assign mag3    = pos3[DATA_W-1] ? (~pos3 + 32'd1) : pos3;
  assign prod1_c = mag1 * inv_step_x1;
  assign prod2_c = mag2 * inv_step_x2;
  assign prod3_c = mag3 * inv_step_x3;

  assign loc1 = locate(neg1, prod1[64:FB], n1);
  assign loc2 = locate(neg2, prod2[64:FB], n2);

  // negative side rounds toward minus infinity before the wrap
  assign q3 = neg3 ? ({1'b0, prod3} + MASK_Q) : {1'b0, prod3};

  // fold the remainder back into [0, period) for negative coordinates
  assign r0      = {mod_rem, low3};
  assign period3 = {n3, {FB{1'b0}}};
  assign r3      = (neg3 && (r0 != '0)) ? (period3 - r0) : r0;
  assign loc3    = locate(1'b0, T_W'(r3), n3);

  assign mod_start = (state == S_LOC);

  // corner address: bit 0 steps axis one, bit 1 axis two, bit 2 axis three
  assign ci      = idx1 + N_W'(cnt[0]);
  assign cj      = idx2 + N_W'(cnt[1]);
  assign ck      = idx3 + N_W'(cnt[2]);
  assign rd_addr = {LOG_CELLS_X1'(ci), LOG_CELLS_X2'(cj), LOG_CELLS_X3'(ck)};
  assign wr_addr = {LOG_CELLS_X1'(s_axis_tdata[5:0]), LOG_CELLS_X2'(s_axis_tdata[11:6]),
                    LOG_CELLS_X3'(s_axis_tdata[16:12])};
  assign mem_we   = in_accept && (s_axis_tuser == OP_WRITE);
  assign mem_addr = (state == S_READ) ? rd_addr : wr_addr;

  gti_grid_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (s_axis_tdata[48:17]),
    .rdata (mem_rdata)
  );

  gti_mod_unit #(.IN_W(IQ_W), .N_W(N_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (q3[64:2*FB]),
    .divisor  (n3),
    .rem      (mod_rem),
    .status   (mod_status)
  );

  // blend order: four along axis one, two along axis two, one along axis three
  always_comb begin
    case (step)
      3'd0:    begin lerp_a = c0; lerp_b = c1; lerp_f = f1; end
      3'd1:    begin lerp_a = c2; lerp_b = c3; lerp_f = f1; end
      3'd2:    begin lerp_a = c4; lerp_b = c5; lerp_f = f1; end
      3'd3:    begin lerp_a = c6; lerp_b = c7; lerp_f = f1; end
      3'd4:    begin lerp_a = w0; lerp_b = w1; lerp_f = f2; end
      3'd5:    begin lerp_a = w2; lerp_b = w3; lerp_f = f2; end
      3'd6:    begin lerp_a = w4; lerp_b = w5; lerp_f = f3; end
      default: begin lerp_a = c0; lerp_b = c1; lerp_f = f1; end
    endcase
  end

  assign lerp_start = (state == S_BLEND) && !issued;

  gti_lerp_unit #(.FB(FB)) u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .a     (lerp_a),
    .b     (lerp_b),
    .f     (lerp_f),
    .res   (lerp_res),
    .done  (lerp_done)
  );

  // saturate the final blend to the signed 32-bit range
  assign v_sat = (w6[DATA_W] != w6[DATA_W-1]) ? (w6[DATA_W] ? SAT_MIN : SAT_MAX)
                                               : w6[DATA_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x1    <= '0;
      start_x2    <= '0;
      inv_step_x1 <= 32'd65536;
      inv_step_x2 <= 32'd65536;
      inv_step_x3 <= 32'd65536;
      size_x1     <= 7'd64;
      size_x2     <= 7'd64;
      size_x3     <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X1:    start_x1    <= cfg_wdata;
        CFG_START_X2:    start_x2    <= cfg_wdata;
        CFG_INV_STEP_X1: inv_step_x1 <= cfg_wdata;
        CFG_INV_STEP_X2: inv_step_x2 <= cfg_wdata;
        CFG_INV_STEP_X3: inv_step_x3 <= cfg_wdata;
        CFG_SIZE_X1:     size_x1     <= cfg_wdata[SIZE1_W-1:0];
        CFG_SIZE_X2:     size_x2     <= cfg_wdata[SIZE2_W-1:0];
        CFG_SIZE_X3:     size_x3     <= cfg_wdata[SIZE3_W-1:0];
        default: ;
      endcase
    end
  end

  // corner capture, one beat of read data per cycle, tagged by corner
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      case (rd_tag)
        3'd0:    c0 <= mem_rdata;
        3'd1:    c1 <= mem_rdata;
        3'd2:    c2 <= mem_rdata;
        3'd3:    c3 <= mem_rdata;
        3'd4:    c4 <= mem_rdata;
        3'd5:    c5 <= mem_rdata;
        3'd6:    c6 <= mem_rdata;
        default: c7 <= mem_rdata;
      endcase
    end
  end

  // query payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos1 <= s_axis_tdata[80:49];
      pos2 <= s_axis_tdata[112:81];
      pos3 <= s_axis_tdata[144:113];
    end
    if (state == S_MUL) begin
      prod1 <= prod1_c;
      prod2 <= prod2_c;
      prod3 <= prod3_c;
      neg1  <= d1[32];
      neg2  <= d2[32];
      neg3  <= pos3[DATA_W-1];
    end
    if (state == S_LOC) begin
      idx1 <= loc1[LOC_W-1:FB+1];
      f1   <= loc1[FB:0];
      idx2 <= loc2[LOC_W-1:FB+1];
      f2   <= loc2[FB:0];
      low3 <= q3[2*FB-1:FB];
    end
    if ((state == S_MOD) && mod_status.done) begin
      idx3 <= loc3[LOC_W-1:FB+1];
      f3   <= loc3[FB:0];
    end
    rd_tag <= cnt;
    if (lerp_done) begin
      case (step)
        3'd0:    w0 <= lerp_res[DATA_W-1:0];
        3'd1:    w1 <= lerp_res[DATA_W-1:0];
        3'd2:    w2 <= lerp_res[DATA_W-1:0];
        3'd3:    w3 <= lerp_res[DATA_W-1:0];
        3'd4:    w4 <= lerp_res[DATA_W-1:0];
        3'd5:    w5 <= lerp_res[DATA_W-1:0];
        default: w6 <= lerp_res;
      endcase
    end
    if ((state == S_OUT) && (!m_valid || m_axis_tready)) begin
      o_value  <= v_sat;
      o_base_i <= BASE12_W'(idx1);
      o_base_j <= BASE12_W'(idx2);
      o_base_k <= BASE3_W'(idx3);
      o_frac1  <= FRAC_OUT_W'(f1);
      o_frac2  <= FRAC_OUT_W'(f2);
      o_frac3  <= FRAC_OUT_W'(f3);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
      step    <= '0;
      issued  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      // drop the beat once taken, unless a new result replaces it
      if (m_valid && m_axis_tready && (state != S_OUT)) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept && (s_axis_tuser == OP_QUERY)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_LOC;
        end
        S_LOC: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_status.done) begin
            cnt   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          cnt     <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            step   <= '0;
            issued <= 1'b0;
            state  <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (lerp_start) begin
            issued <= 1'b1;
          end
          if (lerp_done) begin
            issued <= 1'b0;
            step   <= step + 3'd1;
            if (step == 3'd6) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'd0, o_frac3, o_frac2, o_frac1, o_base_k, o_base_j, o_base_i,
                          o_value};

`include "grid_trilinear_interpolator_macros.svh"

  `GTI_ASSERT_NOW(a_lerp_in_blend, lerp_done, state == S_BLEND, "blend result outside blend")
  `GTI_ASSERT_NOW(a_mod_in_wait, mod_status.busy, state == S_MOD, "remainder unit busy early")
  `GTI_ASSERT_NEXT(a_write_no_beat, in_accept && (s_axis_tuser == OP_WRITE) && !m_valid, !m_valid, "write made a result")
  `GTI_ASSERT_NOW(a_read_no_write, state == S_READ, !mem_we, "write during corner reads")

endmodule

FILE: sv/gti_grid_mem.sv
// ---------------------------------------------------------------------------
// gti_grid_mem
// Single-port grid store, one word per cell, registered read data.
// ---------------------------------------------------------------------------
module gti_grid_mem import gti_pkg::*; #(
  parameter int ADDR_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: sv/gti_mod_unit.sv
// ---------------------------------------------------------------------------
// gti_mod_unit
// Iterative remainder by a small divisor, four dividend bits per cycle.
// ---------------------------------------------------------------------------
module gti_mod_unit import gti_pkg::*; #(
  parameter int IN_W = 33,
  parameter int N_W  = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IN_W-1:0] dividend,
  input  logic [N_W-1:0]  divisor,
  output logic [N_W-1:0]  rem,
  output mod_status_t     status
);

  localparam int R     = 4;
  localparam int PAD_W = ((IN_W + R - 1) / R) * R;
  localparam int CYC   = PAD_W / R;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [PAD_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic [N_W-1:0]   rem_next;
  logic             busy;
  logic             done;

  always_comb begin
    logic [N_W:0] acc;
    acc = {1'b0, rem};
    for (int k = 0; k < R; k++) begin
      acc = {acc[N_W-1:0], sh[PAD_W-1-k]};
      if (acc >= {1'b0, divisor}) begin
        acc = acc - {1'b0, divisor};
      end
    end
    rem_next = acc[N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        sh   <= PAD_W'(dividend);
        rem  <= '0;
        cnt  <= CNT_W'(CYC);
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= sh << R;
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: sv/gti_lerp_unit.sv
// ---------------------------------------------------------------------------
// gti_lerp_unit
// Two-stage linear blend a + floor(((b - a) * f + half) / one).
// ---------------------------------------------------------------------------
module gti_lerp_unit import gti_pkg::*; #(
  parameter int FB = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DATA_W-1:0]        a,
  input  logic [DATA_W-1:0]        b,
  input  logic [FB:0]              f,
  output logic signed [DATA_W:0]   res,
  output logic                     done
);

  localparam int P_W = DATA_W + 1 + FB + 2;
  localparam logic signed [P_W-1:0] HALF = {{(P_W-1){1'b0}}, 1'b1} << (FB - 1);

  logic signed [DATA_W:0]   diff;
  logic signed [FB+1:0]     fs;
  logic signed [P_W-1:0]    prod_c;
  logic signed [P_W-1:0]    prod;
  logic signed [P_W-1:0]    shifted;
  logic [DATA_W-1:0]        a_r;
  logic                     s1;

  assign diff    = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
  assign fs      = $signed({1'b0, f});
  assign prod_c  = diff * fs;
  assign shifted = (prod + HALF) >>> FB;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= prod_c;
      a_r  <= a;
    end
    if (s1) begin
      res <= $signed({a_r[DATA_W-1], a_r}) + $signed(shifted[DATA_W:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start;
      done <= s1;
    end
  end

endmodule
